>>> src/quaternion_nlerp_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the quaternion nlerp unit
// Shared helpers for concurrent checks, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_NLERP_UNIT_MACROS_SVH
`define QUATERNION_NLERP_UNIT_MACROS_SVH

// check outside reset
`define QN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check that also holds across reset
`define QN_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/qnlerp_pkg.sv
// ----------------------------------------------------------------------------
// qnlerp_pkg
// Widths and pipeline stage types for the quaternion nlerp unit.
// ----------------------------------------------------------------------------
package qnlerp_pkg;

  localparam int unsigned CompW   = 16;        // Q2.14 component
  localparam int unsigned WeightW = 17;
  localparam logic [16:0] WeightOne = 17'h10000;
  localparam int unsigned DiffW   = 18;        // b' - a
  localparam int unsigned BlendW  = 34;        // a*65536 + w*(b'-a)
  localparam int unsigned SqW     = 63;        // |R|^2 <= 2^62
  localparam int unsigned SumW    = 65;        // sum of four squares
  localparam int unsigned QuoW    = 31;        // floor(2^30 R^2 / S)
  localparam int unsigned RootW   = 16;
  localparam int unsigned SremW   = 18;
  localparam int unsigned DivSteps  = QuoW;
  localparam int unsigned SqrtSteps = RootW;

  typedef struct packed {
    logic [SumW-1:0] rem;
    logic [QuoW-1:0] quo;
    logic            neg;
  } div_lane_t;

  typedef struct packed {
    div_lane_t [3:0] lane;
    logic [SumW-1:0] s;
    logic            deg;
  } div_stage_t;

  typedef struct packed {
    logic [SremW-1:0] rem;
    logic [RootW-1:0] root;
    logic [31:0]      qv;
    logic             neg;
  } sqrt_lane_t;

  typedef struct packed {
    sqrt_lane_t [3:0] lane;
    logic             deg;
  } sqrt_stage_t;

endpackage

>>> src/quaternion_nlerp_unit.sv
// ----------------------------------------------------------------------------
// quaternion_nlerp_unit
// Normalised linear interpolation of two Q2.14 quaternions, exact rounding.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side (s_tvalid/s_tready/s_tdata) takes a pair of quaternions a, b
//   and a 17-bit weight; master side (m_tvalid/m_tready/m_tdata/m_tuser)
//   returns the normalised blend and the degenerate flag, one result per
//   input transfer, in order.
//   Throughput: one transfer per cycle while the output is not stalled.
//   The pipeline is 53 register stages deep (5 arithmetic stages, 31
//   restoring divide steps, 16 square root steps, output register); one
//   quotient bit or one root bit per stage sets that depth.
//   Reset clears every valid bit; no result is pending afterwards.
//   Stall: the whole pipeline holds while a result sits in the output
//   register and m_tready is low; s_tready drops for exactly those cycles,
//   so nothing is lost or repeated. Bubbles hold as well; none are removed.
//   Method: R = a*65536 + w*(b'-a), S = sum R^2, Q = floor(2^30 R^2 / S),
//   m = isqrt(Q), |r| = (m+1)/2, sign of R applied.
// ----------------------------------------------------------------------------
module quaternion_nlerp_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w (16 each), weight (17), zero pad
  input  logic [151:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // r_x, r_y, r_z, r_w (16 each)
  output logic [63:0]  m_tdata,
  // degenerate
  output logic         m_tuser
);

  // global advance: output register empty or being drained
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // --------------------------------------------------------------------------
  // stage 1: dot product terms, weight clamp
  // --------------------------------------------------------------------------
  logic                                 v1;
  logic signed [qnlerp_pkg::CompW-1:0]  a1 [4];
  logic signed [qnlerp_pkg::CompW-1:0]  b1 [4];
  logic signed [31:0]                   p1 [4];
  logic [qnlerp_pkg::WeightW-1:0]       w1;

  logic [qnlerp_pkg::WeightW-1:0] w_in;
  assign w_in = s_tdata[144:128];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        a1[i] <= $signed(s_tdata[16*i +: 16]);
        b1[i] <= $signed(s_tdata[64 + 16*i +: 16]);
        p1[i] <= $signed(s_tdata[16*i +: 16]) * $signed(s_tdata[64 + 16*i +: 16]);
      end
      w1 <= (w_in > qnlerp_pkg::WeightOne) ? qnlerp_pkg::WeightOne : w_in;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: dot sign, shortest arc, difference b' - a
  // --------------------------------------------------------------------------
  logic                                 v2;
  logic signed [qnlerp_pkg::CompW-1:0]  a2 [4];
  logic signed [qnlerp_pkg::DiffW-1:0]  d2 [4];
  logic [qnlerp_pkg::WeightW-1:0]       w2;

  logic signed [33:0] dot;
  logic               flip;
  assign dot  = 34'(p1[0]) + 34'(p1[1]) + 34'(p1[2]) + 34'(p1[3]);
  assign flip = dot[33];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        a2[i] <= a1[i];
        d2[i] <= (flip ? -18'(b1[i]) : 18'(b1[i])) - 18'(a1[i]);
      end
      w2 <= w1;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: blended components R
  // --------------------------------------------------------------------------
  logic                                  v3;
  logic signed [qnlerp_pkg::BlendW-1:0]  r3 [4];
  logic signed [35:0]                    wd [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      wd[i] = $signed({1'b0, w2}) * d2[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  // a*65536 sign-extended to the blend width
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        r3[i] <= {{2{a2[i][qnlerp_pkg::CompW-1]}}, a2[i], 16'b0} + wd[i][33:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: squares
  // --------------------------------------------------------------------------
  logic                         v4;
  logic [qnlerp_pkg::SqW-1:0]   sq4  [4];
  logic                         neg4 [4];
  logic [33:0]                  mag  [4];
  logic [63:0]                  sqf  [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mag[i] = r3[i][33] ? -r3[i] : r3[i];
      sqf[i] = mag[i][31:0] * mag[i][31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        sq4[i]  <= sqf[i][62:0];
        neg4[i] <= r3[i][33];
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 5: squared length S
  // --------------------------------------------------------------------------
  logic                         v5;
  logic [qnlerp_pkg::SqW-1:0]   sq5  [4];
  logic                         neg5 [4];
  logic [qnlerp_pkg::SumW-1:0]  s5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq5  <= sq4;
      neg5 <= neg4;
      s5   <= 65'(sq4[0]) + 65'(sq4[1]) + 65'(sq4[2]) + 65'(sq4[3]);
    end
  end

  // --------------------------------------------------------------------------
  // restoring divide: Q = floor(2^30 * R^2 / S), one quotient bit a stage.
  // R^2 <= S, so the top of the dividend (R^2 >> 1) is already below S.
  // --------------------------------------------------------------------------
  logic                   dv      [qnlerp_pkg::DivSteps];
  qnlerp_pkg::div_stage_t dst     [qnlerp_pkg::DivSteps];
  qnlerp_pkg::div_stage_t dst_nxt [qnlerp_pkg::DivSteps];

  always_comb begin
    qnlerp_pkg::div_stage_t src;
    logic [qnlerp_pkg::SumW:0] t;
    logic                      ge;
    for (int k = 0; k < qnlerp_pkg::DivSteps; k++) begin
      if (k == 0) begin
        for (int i = 0; i < 4; i++) begin
          src.lane[i].rem = 65'(sq5[i][62:1]);
          src.lane[i].quo = '0;
          src.lane[i].neg = neg5[i];
        end
        src.s   = s5;
        src.deg = (s5 == '0);
      end else begin
        src = dst[k-1];
      end
      dst_nxt[k] = src;
      for (int i = 0; i < 4; i++) begin
        // only the first step brings in a non-zero dividend bit (R^2 bit 0)
        t  = {src.lane[i].rem, (k == 0) ? sq5[i][0] : 1'b0};
        ge = (t >= {1'b0, src.s});
        dst_nxt[k].lane[i].rem = ge ? 65'(t - {1'b0, src.s}) : t[64:0];
        dst_nxt[k].lane[i].quo = {src.lane[i].quo[29:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < qnlerp_pkg::DivSteps; k++) dv[k] <= 1'b0;
    end else if (en) begin
      dv[0] <= v5;
      for (int k = 1; k < qnlerp_pkg::DivSteps; k++) dv[k] <= dv[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dst <= dst_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // integer square root of Q, one root bit a stage
  // --------------------------------------------------------------------------
  logic                    sv      [qnlerp_pkg::SqrtSteps];
  qnlerp_pkg::sqrt_stage_t sst     [qnlerp_pkg::SqrtSteps];
  qnlerp_pkg::sqrt_stage_t sst_nxt [qnlerp_pkg::SqrtSteps];

  always_comb begin
    qnlerp_pkg::sqrt_stage_t src;
    logic [19:0]             t;
    logic [17:0]             trial;
    logic                    ge;
    for (int k = 0; k < qnlerp_pkg::SqrtSteps; k++) begin
      if (k == 0) begin
        for (int i = 0; i < 4; i++) begin
          src.lane[i].rem  = '0;
          src.lane[i].root = '0;
          src.lane[i].qv   = {1'b0, dst[qnlerp_pkg::DivSteps-1].lane[i].quo};
          src.lane[i].neg  = dst[qnlerp_pkg::DivSteps-1].lane[i].neg;
        end
        src.deg = dst[qnlerp_pkg::DivSteps-1].deg;
      end else begin
        src = sst[k-1];
      end
      sst_nxt[k] = src;
      for (int i = 0; i < 4; i++) begin
        t     = {src.lane[i].rem, src.lane[i].qv[31:30]};
        trial = {src.lane[i].root, 2'b01};
        ge    = (t >= 20'(trial));
        sst_nxt[k].lane[i].rem  = ge ? 18'(t - 20'(trial)) : t[17:0];
        sst_nxt[k].lane[i].root = {src.lane[i].root[14:0], ge};
        sst_nxt[k].lane[i].qv   = {src.lane[i].qv[29:0], 2'b00};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < qnlerp_pkg::SqrtSteps; k++) sv[k] <= 1'b0;
    end else if (en) begin
      sv[0] <= dv[qnlerp_pkg::DivSteps-1];
      for (int k = 1; k < qnlerp_pkg::SqrtSteps; k++) sv[k] <= sv[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sst <= sst_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // output register: |r| = (m + 1) / 2, sign restored, zero if degenerate
  // --------------------------------------------------------------------------
  qnlerp_pkg::sqrt_stage_t last;
  logic [16:0]             kk   [4];
  logic [63:0]             res;

  assign last = sst[qnlerp_pkg::SqrtSteps-1];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      kk[i] = 17'(last.lane[i].root) + 17'd1;
      if (last.deg) begin
        res[16*i +: 16] = '0;
      end else if (last.lane[i].neg) begin
        res[16*i +: 16] = -kk[i][16:1];
      end else begin
        res[16*i +: 16] = kk[i][16:1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= sv[qnlerp_pkg::SqrtSteps-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= res;
      m_tuser <= last.deg;
    end
  end

endmodule

>>> src/qnlerp_checker.sv
// ----------------------------------------------------------------------------
// qnlerp_checker
// Port-level checks for the quaternion nlerp unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "quaternion_nlerp_unit_macros.svh"

module qnlerp_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [63:0]  m_tdata,
  input logic         m_tuser
);

  `QN_ASSERT_ALWAYS(a_rst_clears, $past(rst) |-> !m_tvalid, "result valid right after reset")

  `QN_ASSERT(a_ready_rule, s_tready == (!m_tvalid || m_tready), "input ready does not follow stall")

  `QN_ASSERT(a_deg_zero, (m_tvalid && m_tuser) |-> (m_tdata == 64'd0), "degenerate result not zero")

  `QN_ASSERT(a_unit_range, m_tvalid |-> ($signed(m_tdata[15:0]) <= 16'sd16384 && $signed(m_tdata[15:0]) >= -16'sd16384 && $signed(m_tdata[63:48]) <= 16'sd16384 && $signed(m_tdata[63:48]) >= -16'sd16384), "component above unit length")

  `QN_ASSERT(a_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)), "stalled result changed")

endmodule

bind quaternion_nlerp_unit qnlerp_checker u_qnlerp_checker (.*);

>>> dv/quaternion_nlerp_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quaternion_nlerp_checker
// Watches both channels of the nlerp unit, predicts each normalised blend
// from the input transfer and compares it with the output transfer.
// ----------------------------------------------------------------------------
module quaternion_nlerp_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [151:0] s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [63:0]  m_tdata,
  input  logic         m_tuser,
  output int           fail_count,
  output int           pending
);

  typedef struct packed {
    logic [15:0] rw, rz, ry, rx;
    logic        deg;
  } blend_t;

  blend_t blend_q[$];

  // exact nlerp: dot sign, blend, then largest k with (2k-1)^2 S <= 2^30 R^2
  function automatic blend_t predict_blend(logic [151:0] d);
    blend_t          res;
    longint          a[4], b[4], r[4];
    longint          dot, bn, w;
    logic [127:0]    s, sq, lhs, rhs;
    longint unsigned mag;
    int              lo, hi, mid;
    logic [15:0]     comp[4];
    dot = 0;
    for (int i = 0; i < 4; i++) begin
      a[i] = longint'($signed(d[16*i +: 16]));
      b[i] = longint'($signed(d[64 + 16*i +: 16]));
      dot += a[i] * b[i];
    end
    w = longint'(d[128 +: 17]);
    if (w > 65536) w = 65536;
    s = 0;
    for (int i = 0; i < 4; i++) begin
      bn = (dot < 0) ? -b[i] : b[i];
      r[i] = a[i] * 65536 + w * (bn - a[i]);
      mag = (r[i] < 0) ? -r[i] : r[i];
      s += 128'(mag) * 128'(mag);
    end
    res = '0;
    if (s == 0) begin
      res.deg = 1'b1;
      return res;
    end
    for (int i = 0; i < 4; i++) begin
      mag = (r[i] < 0) ? -r[i] : r[i];
      sq = 128'(mag) * 128'(mag);
      rhs = sq << 30;
      lo = 0;
      hi = 16384;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        lhs = 128'((2*mid - 1) * (2*mid - 1)) * s;
        if (lhs <= rhs) lo = mid;
        else hi = mid - 1;
      end
      comp[i] = (r[i] < 0) ? 16'(-lo) : 16'(lo);
    end
    res.rx = comp[0]; res.ry = comp[1]; res.rz = comp[2]; res.rw = comp[3];
    return res;
  endfunction

  assign pending = blend_q.size();

  always @(posedge clk) begin
    blend_t got, exp_r;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (s_tvalid && s_tready) blend_q.push_back(predict_blend(s_tdata));
      if (m_tvalid && m_tready) begin
        got = {m_tdata[63:48], m_tdata[47:32], m_tdata[31:16], m_tdata[15:0], m_tuser};
        if (blend_q.size() == 0) begin
          $display("%0t: unexpected transfer, expected none, actual %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = blend_q.pop_front();
          if (got !== exp_r) begin
            $display("%0t: expected x=%h y=%h z=%h w=%h deg=%b, actual x=%h y=%h z=%h w=%h deg=%b",
                     $time, exp_r.rx, exp_r.ry, exp_r.rz, exp_r.rw, exp_r.deg,
                     got.rx, got.ry, got.rz, got.rw, got.deg);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

>>> dv/quaternion_nlerp_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quaternion_nlerp_unit_tb
// Drives directed and random quaternion pairs with random gaps and output
// stalls; the checker predicts and compares, this module gives the verdict.
// ----------------------------------------------------------------------------
module quaternion_nlerp_unit_tb;

  localparam int Latency  = 52;
  localparam int IdleLimit = 2000;   // cycles with no transfer at all

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w (16 each), weight (17), zero pad
  logic [151:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  // r_x, r_y, r_z, r_w (16 each)
  logic [63:0]  m_tdata;
  logic         m_tuser;   // degenerate
  int           fail_count;
  int           pending;
  int           idle_cycles;

  quaternion_nlerp_unit DUT (.*);

  quaternion_nlerp_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // one transfer, after a random gap
  task automatic send_pair(logic [15:0] q[8], logic [qnlerp_pkg::WeightW-1:0] w);
    int gap;
    gap = $urandom_range(0, 12);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'b0, w, q[7], q[6], q[5], q[4], q[3], q[2], q[1], q[0]};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [15:0] rand_comp();
    unique case ($urandom_range(0, 5))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h4000;
      3:       return 16'($signed($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [qnlerp_pkg::WeightW-1:0] rand_weight();
    unique case ($urandom_range(0, 7))
      0:       return '0;
      1:       return qnlerp_pkg::WeightOne;
      2:       return 17'($urandom_range(65537, 131071));   // saturates
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  // output stall: a random hold-off per result, with stall-free stretches
  initial begin
    int hold;
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      repeat (hold) begin
        m_tready <= 1'b0;
        @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    logic [15:0] q[8];
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    rst       = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: identity blends, extremes, opposite quaternions, zero dot,
    // zero length, saturated weight, all-ones fields
    for (int k = 0; k < 20; k++) begin
      for (int i = 0; i < 8; i++) q[i] = 16'h0000;
      unique case (k)
        0:  begin q[3] = 16'h4000; q[7] = 16'h4000; end
        1:  begin q[0] = 16'h7FFF; q[4] = 16'h8000; end         // opposite
        2:  begin q[0] = 16'h4000; q[5] = 16'h4000; end         // dot zero
        3:  ;                                                    // all zero
        4:  begin q[2] = 16'h4000; q[6] = 16'hC000; end          // b = -a, equal after the flip
        5:  for (int i = 0; i < 8; i++) q[i] = 16'h8000;
        6:  for (int i = 0; i < 8; i++) q[i] = 16'h7FFF;
        7:  for (int i = 0; i < 8; i++) q[i] = 16'hFFFF;
        8:  for (int i = 0; i < 8; i++) q[i] = (i < 4) ? 16'h7FFF : 16'h8000;
        9:  begin q[0] = 16'h0001; q[7] = 16'h0001; end
        default: for (int i = 0; i < 8; i++) q[i] = rand_comp();
      endcase
      send_pair(q, (k % 4 == 0) ? 17'h00000 : (k % 4 == 1) ? qnlerp_pkg::WeightOne :
                   (k % 4 == 2) ? 17'h1FFFF : 17'h08000);
    end

    // random part
    for (int n = 0; n < 700; n++) begin
      for (int i = 0; i < 8; i++) q[i] = rand_comp();
      if ($urandom_range(0, 9) == 0) for (int i = 0; i < 4; i++) q[4+i] = -q[i];
      send_pair(q, rand_weight());
    end
    s_tvalid  <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (Latency + 10) @(posedge clk);
    if (fail_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/qnlerp_pkg.sv
src/quaternion_nlerp_unit.sv
src/qnlerp_checker.sv
dv/quaternion_nlerp_checker.sv
dv/quaternion_nlerp_unit_tb.sv
